// ===== design/tbs_pkg.sv =====
package tbs_pkg;

  localparam int NUM_SLOTS   = 8;
  localparam int SLOT_W      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int QUEUE_DEPTH = 2;

  localparam logic KIND_LOAD    = 1'b0;
  localparam logic KIND_REQUEST = 1'b1;

  // blend weights 0.35 and 0.65 in q16, they sum to exactly 1.0
  localparam logic [14:0] W_PREV = 15'd22938;
  localparam logic [15:0] W_LAST = 16'd42598;

  // buffer tier factors in q16
  localparam logic [16:0] F_LOW  = 17'd21627;
  localparam logic [16:0] F_MID  = 17'd43254;
  localparam logic [16:0] F_ONE  = 17'd65536;
  localparam logic [16:0] F_HIGH = 17'd72090;

  localparam logic [19:0] BUF_LOW  = 20'd4000;
  localparam logic [19:0] BUF_MID  = 20'd8000;
  localparam logic [19:0] BUF_HIGH = 20'd16000;

  typedef enum logic [1:0] {
    TIER_LOW,
    TIER_MID,
    TIER_ONE,
    TIER_HIGH
  } tier_t;

  typedef struct packed {
    logic        is_req;
    logic [2:0]  slot;
    logic [31:0] rate;   // representation rate for loads, measured rate for requests
    tier_t       tier;
  } q_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_PREV,
    ST_MUL_LAST,
    ST_BLEND,
    ST_SCALE,
    ST_SCAN,
    ST_FINISH
  } back_state_t;

  function automatic logic [16:0] tier_factor(tier_t t);
    logic [16:0] f;
    unique case (t)
      TIER_LOW:  f = F_LOW;
      TIER_MID:  f = F_MID;
      TIER_ONE:  f = F_ONE;
      TIER_HIGH: f = F_HIGH;
      default:   f = F_ONE;
    endcase
    return f;
  endfunction

endpackage

// ===== design/tbs_front.sv =====
module tbs_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             kind,
  input  logic [2:0]       rep_slot,
  input  logic [31:0]      rep_rate,
  input  logic [19:0]      buffer_ms,
  input  logic [31:0]      measured_rate,
  output logic             q_valid,
  output tbs_pkg::q_item_t q_item,
  input  logic             q_pop
);
  import tbs_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  q_item_t            entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  q_item_t            item_in;
  logic               keep;
  logic               push;

  // classify the beat: pick the payload word and the buffer tier
  always_comb begin
    item_in.is_req = (kind == KIND_REQUEST);
    item_in.slot   = rep_slot;
    item_in.rate   = (kind == KIND_REQUEST) ? measured_rate : rep_rate;
    priority if (buffer_ms < BUF_LOW) begin
      item_in.tier = TIER_LOW;
    end else if (buffer_ms < BUF_MID) begin
      item_in.tier = TIER_MID;
    end else if (buffer_ms < BUF_HIGH) begin
      item_in.tier = TIER_ONE;
    end else begin
      item_in.tier = TIER_HIGH;
    end
  end

  // loads to a slot beyond the table are dropped here
  assign keep     = item_in.is_req || (32'(rep_slot) < NUM_SLOTS);
  assign in_ready = (count != CNT_W'(QUEUE_DEPTH));
  assign push     = in_valid && in_ready && keep;
  assign q_valid  = (count != '0);
  assign q_item   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !q_pop) begin
        count <= count + 1'b1;
      end else if (!push && q_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== design/tbs_back.sv =====
module tbs_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  tbs_pkg::q_item_t q_item,
  output logic             q_pop,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [15:0]      cfg_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             all_done,
  output logic [2:0]       chosen_slot,
  output logic             none_loaded,
  output logic [15:0]      segment_number
);
  import tbs_pkg::*;

  back_state_t          state;
  back_state_t          state_next;

  logic [15:0]          total_segments;
  logic [15:0]          seg_counter;
  logic [31:0]          prev_rate;
  logic [31:0]          rate_table [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] slot_valid;

  logic [31:0]          cur_last;
  tier_t                cur_tier;
  logic                 is_done;
  logic [46:0]          acc_prev;
  logic [47:0]          prod_last;
  logic [31:0]          weighted;
  logic [32:0]          limit;
  logic [SLOT_W-1:0]    idx;
  logic                 any_valid;
  logic                 found;
  logic [SLOT_W-1:0]    best_idx;
  logic [SLOT_W-1:0]    low_idx;
  logic [31:0]          best_rate;
  logic [31:0]          low_rate;

  logic                 load_we;
  logic                 start_req;
  logic                 out_load;
  logic                 scan_last;

  logic [47:0]          blend_sum;
  logic [48:0]          scaled;
  logic [31:0]          cur_rate;
  logic                 cur_valid;
  logic                 take_low;
  logic                 take_best;

  assign cfg_ready = 1'b1;
  assign scan_last = (idx == SLOT_W'(NUM_SLOTS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    load_we    = 1'b0;
    start_req  = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_item.is_req) begin
            start_req  = 1'b1;
            state_next = (seg_counter >= total_segments) ? ST_FINISH : ST_MUL_PREV;
          end else begin
            load_we = 1'b1;
          end
        end
      end
      ST_MUL_PREV: state_next = ST_MUL_LAST;
      ST_MUL_LAST: state_next = ST_BLEND;
      ST_BLEND:    state_next = ST_SCALE;
      ST_SCALE:    state_next = ST_SCAN;
      ST_SCAN: begin
        if (scan_last) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign blend_sum = 48'(acc_prev) + prod_last;
  assign scaled    = weighted * tier_factor(cur_tier);

  // one table entry per scan cycle, strict compares keep the lowest slot on ties
  assign cur_rate  = rate_table[idx];
  assign cur_valid = slot_valid[idx];
  assign take_low  = cur_valid && (!any_valid || (cur_rate < low_rate));
  assign take_best = cur_valid && ({1'b0, cur_rate} < limit)
                     && (!found || (cur_rate > best_rate));

  always_ff @(posedge clk) begin
    if (load_we) begin
      rate_table[SLOT_W'(q_item.slot)] <= q_item.rate;
    end
    if (start_req) begin
      cur_last <= q_item.rate;
      cur_tier <= q_item.tier;
      idx      <= '0;
    end
    if (state == ST_MUL_PREV) begin
      acc_prev <= prev_rate * W_PREV;
    end
    if (state == ST_MUL_LAST) begin
      prod_last <= cur_last * W_LAST;
    end
    if (state == ST_BLEND) begin
      weighted <= (prev_rate == '0) ? cur_last : blend_sum[47:16];
    end
    if (state == ST_SCALE) begin
      limit <= scaled[48:16];
    end
    if (state == ST_SCAN) begin
      idx <= idx + 1'b1;
      if (take_low) begin
        low_idx  <= idx;
        low_rate <= cur_rate;
      end
      if (take_best) begin
        best_idx  <= idx;
        best_rate <= cur_rate;
      end
    end
    if (out_load) begin
      all_done       <= is_done;
      chosen_slot    <= (is_done || !any_valid) ? 3'd0
                        : (found ? 3'(best_idx) : 3'(low_idx));
      none_loaded    <= !is_done && !any_valid;
      segment_number <= is_done ? 16'd0 : seg_counter;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total_segments <= '0;
      seg_counter    <= '0;
      prev_rate      <= '0;
      slot_valid     <= '0;
      is_done        <= 1'b0;
      any_valid      <= 1'b0;
      found          <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        total_segments <= cfg_data;
      end
      if (load_we) begin
        slot_valid[SLOT_W'(q_item.slot)] <= 1'b1;
      end
      if (start_req) begin
        is_done   <= (seg_counter >= total_segments);
        any_valid <= 1'b0;
        found     <= 1'b0;
      end
      if (state == ST_SCAN) begin
        if (cur_valid) begin
          any_valid <= 1'b1;
        end
        if (take_best) begin
          found <= 1'b1;
        end
      end
      if (out_load && !is_done) begin
        prev_rate   <= cur_last;
        seg_counter <= seg_counter + 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== design/throughput_bitrate_selector.sv =====
// Throughput-driven bitrate selector. Load beats (kind 0) write one slot of an
// eight-entry bitrate table and give no result; request beats (kind 1) give one
// result each, in order. A two-entry queue sits between the input side and the
// execution unit, and a result register sits on the output, so new beats are
// taken while a result waits. A load is written at pop; a request steps through
// pop, two q16 weight multiplies, blend, tier scale, one table slot per cycle
// over eight slots, then result load; a request that finds the stream finished
// goes from pop straight to result load. The table scan sets the request time.
// There is no clearing pass after reset. total_segments is written on the cfg
// channel, which is always ready, and should only change while the block idles.
module throughput_bitrate_selector (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        kind,
  input  logic [2:0]  rep_slot,
  input  logic [31:0] rep_rate,
  input  logic [19:0] buffer_ms,
  input  logic [31:0] measured_rate,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        all_done,
  output logic [2:0]  chosen_slot,
  output logic        none_loaded,
  output logic [15:0] segment_number
);
  import tbs_pkg::*;

  logic    q_valid;
  logic    q_pop;
  q_item_t q_item;

  tbs_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .kind          (kind),
    .rep_slot      (rep_slot),
    .rep_rate      (rep_rate),
    .buffer_ms     (buffer_ms),
    .measured_rate (measured_rate),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop)
  );

  tbs_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .all_done       (all_done),
    .chosen_slot    (chosen_slot),
    .none_loaded    (none_loaded),
    .segment_number (segment_number)
  );

endmodule
